### rtl/core/kfc_pkg.sv
// kfc_pkg: shared types, codes and the keyword table of the keyword frequency counter
// used by kfc_word, kfc_cell and keyword_frequency_counter_top; no dependencies
package kfc_pkg;

    localparam int TABLE_KEYS   = 15;
    localparam int PREFIX_CHARS = 8;
    localparam int INDEX_W      = 4;
    localparam int LEN_W        = 4;

    // tuser codes on the input side
    localparam logic ACT_TEXT = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_REPORT
    } kfc_state_t;

    // finished word travelling along the cell row
    typedef struct packed {
        logic                         valid;
        logic [LEN_W-1:0]             len;
        logic [8*PREFIX_CHARS-1:0]    prefix;
    } word_beat_t;

    // keyword text as string literals, right-aligned, first character in the top used byte
    localparam logic [8*PREFIX_CHARS-1:0] KW_TEXT [TABLE_KEYS] = '{
        64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
        64'("continue"), 64'("default"), 64'("do"), 64'("float"), 64'("for"),
        64'("if"), 64'("int"), 64'("struct"), 64'("unsigned"), 64'("void")
    };

    localparam logic [LEN_W-1:0] KW_LEN [TABLE_KEYS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd5, 4'd3, 4'd2, 4'd3, 4'd6, 4'd8, 4'd4
    };

    // keyword packed with character i in bits 8i+7..8i, unused bytes zero
    function automatic logic [8*PREFIX_CHARS-1:0] kw_prefix(input int k);
        logic [8*PREFIX_CHARS-1:0] text;
        logic [8*PREFIX_CHARS-1:0] res;
        int                        n;
        text = KW_TEXT[k];
        n    = int'(KW_LEN[k]);
        res  = '0;
        for (int i = 0; i < PREFIX_CHARS; i++)
        begin
            if (i < n)
            begin
                res[8*i +: 8] = text[8*(n-1-i) +: 8];
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/kfc_word.sv
// kfc_word: splits the byte stream into words and emits each finished short word as a beat
// depends on kfc_pkg
module kfc_word
    import kfc_pkg::*;
#(
    parameter int MAX_WORD_CHARS = 100
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic       action,
    input  logic [7:0] text_byte,
    output word_beat_t beat
);

    localparam int WLEN_W = $clog2(MAX_WORD_CHARS + 1);

    logic [8*PREFIX_CHARS-1:0] prefix_reg, prefix_next;
    logic [WLEN_W-1:0]         length_reg, length_next;
    logic                      valid_reg, valid_next;
    logic [LEN_W-1:0]          len_reg;
    logic [8*PREFIX_CHARS-1:0] out_prefix_reg;
    logic                      letter, digit, finish;

    assign letter = (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
                    (text_byte >= 8'h61 && text_byte <= 8'h7A);
    assign digit  = (text_byte >= 8'h30 && text_byte <= 8'h39);

    always_comb
    begin
        prefix_next = prefix_reg;
        length_next = length_reg;
        finish      = 1'b0;
        if (take)
        begin
            if (action == ACT_END)
            begin
                finish      = (length_reg != '0);
                prefix_next = '0;
                length_next = '0;
            end
            else if (length_reg != '0 && (letter || digit) &&
                     length_reg < WLEN_W'(MAX_WORD_CHARS))
            begin
                // only the first eight characters are kept
                for (int i = 0; i < PREFIX_CHARS; i++)
                begin
                    if (length_reg == WLEN_W'(i))
                    begin
                        prefix_next[8*i +: 8] = text_byte;
                    end
                end
                length_next = length_reg + WLEN_W'(1);
            end
            else
            begin
                finish = (length_reg != '0);
                if (letter)
                begin
                    prefix_next = 64'(text_byte);
                    length_next = WLEN_W'(1);
                end
                else
                begin
                    prefix_next = '0;
                    length_next = '0;
                end
            end
        end
        // words longer than any keyword never match, so they are dropped here
        valid_next = finish && (length_reg <= WLEN_W'(PREFIX_CHARS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg <= '0;
            length_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            prefix_reg <= prefix_next;
            length_reg <= length_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= length_reg[LEN_W-1:0];
        out_prefix_reg <= prefix_reg;
    end

    assign beat.valid  = valid_reg;
    assign beat.len    = len_reg;
    assign beat.prefix = out_prefix_reg;

endmodule

### rtl/core/kfc_cell.sv
// kfc_cell: one keyword's counter; passes word beats on and shifts counts during a report
// depends on kfc_pkg
module kfc_cell
    import kfc_pkg::*;
#(
    parameter int KEY         = 0,
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  word_beat_t             beat_in,
    input  logic                   shift,
    input  logic [COUNT_WIDTH-1:0] count_in,
    output word_beat_t             beat_out,
    output logic [COUNT_WIDTH-1:0] count
);

    localparam logic [8*PREFIX_CHARS-1:0] KEY_PREFIX = kw_prefix(KEY);
    localparam logic [LEN_W-1:0]          KEY_LEN    = KW_LEN[KEY];

    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic                      valid_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [8*PREFIX_CHARS-1:0] prefix_reg;
    logic                      hit;

    assign hit = beat_in.valid && beat_in.len == KEY_LEN && beat_in.prefix == KEY_PREFIX;

    always_comb
    begin
        count_next = count_reg;
        priority if (shift)
        begin
            count_next = count_in;
        end
        else if (hit && count_reg != '1)
        begin
            count_next = count_reg + COUNT_WIDTH'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            valid_reg <= beat_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= beat_in.len;
        prefix_reg <= beat_in.prefix;
    end

    assign beat_out.valid  = valid_reg;
    assign beat_out.len    = len_reg;
    assign beat_out.prefix = prefix_reg;
    assign count           = count_reg;

endmodule

### rtl/core/keyword_frequency_counter_top.sv
// keyword_frequency_counter_top: word splitter, row of keyword cells and report control
// depends on kfc_pkg, kfc_word, kfc_cell
//
// channel   dir  beat contents
// s_axis    in   tdata[7:0] text_byte, tuser action (1 = end of input)
// m_axis    out  tdata[3:0] key_index, tdata[35:4] key_count, tlast last_of_report
//
// a text byte is taken every cycle while s_axis_tready is high; the word beat then walks the cell row one cell a cycle
// an end beat blocks input while the row drains (KEYS = min(NUM_KEYS, 15)),
// then KEYS report beats follow, one per cycle while m_axis_tready is high
// the report shifts counts out of the row, leaving every counter at zero
// reset is asynchronous and clears the pending word, the counters and the control state
module keyword_frequency_counter_top
    import kfc_pkg::*;
#(
    parameter int NUM_KEYS       = 15,
    parameter int MAX_WORD_CHARS = 100,
    parameter int COUNT_WIDTH    = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [3:0] key_index, [35:4] key_count, rest zero
    output logic        m_axis_tlast    // last_of_report
);

    localparam int ACTIVE_KEYS = (NUM_KEYS < TABLE_KEYS) ? NUM_KEYS : TABLE_KEYS;
    localparam int DRAIN_W     = $clog2(ACTIVE_KEYS + 1);

    kfc_state_t              state_reg, state_next;
    logic [DRAIN_W-1:0]      drain_reg, drain_next;
    logic [INDEX_W-1:0]      index_reg, index_next;
    logic                    in_take, out_take;
    word_beat_t              beats [ACTIVE_KEYS+1];
    logic [COUNT_WIDTH-1:0]  counts [ACTIVE_KEYS+1];
    logic [ACTIVE_KEYS:0]    beat_live;
    logic [63:0]             count_wide;

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_take = m_axis_tvalid && m_axis_tready;

    kfc_word #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_word (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .action    (s_axis_tuser),
        .text_byte (s_axis_tdata),
        .beat      (beats[0])
    );

    // last cell pulls in zeros, so the report leaves the row cleared
    assign counts[ACTIVE_KEYS] = '0;

    for (genvar k = 0; k < ACTIVE_KEYS; k++)
    begin : g_cell
        kfc_cell #(
            .KEY         (k),
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .beat_in  (beats[k]),
            .shift    (out_take),
            .count_in (counts[k+1]),
            .beat_out (beats[k+1]),
            .count    (counts[k])
        );
    end

    for (genvar k = 0; k <= ACTIVE_KEYS; k++)
    begin : g_live
        assign beat_live[k] = beats[k].valid;
    end

    always_comb
    begin
        state_next = state_reg;
        drain_next = drain_reg;
        index_next = index_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && s_axis_tuser == ACT_END)
                begin
                    state_next = ST_DRAIN;
                    drain_next = '0;
                end
            end
            ST_DRAIN:
            begin
                // wait until the flushed word has passed the last cell
                drain_next = drain_reg + DRAIN_W'(1);
                if (drain_reg == DRAIN_W'(ACTIVE_KEYS))
                begin
                    state_next = ST_REPORT;
                    index_next = '0;
                end
            end
            ST_REPORT:
            begin
                if (out_take)
                begin
                    index_next = index_reg + INDEX_W'(1);
                    if (index_reg == INDEX_W'(ACTIVE_KEYS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
            index_reg <= index_next;
        end
    end

    assign count_wide    = 64'(counts[0]);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_REPORT);
    assign m_axis_tdata  = {4'b0000, count_wide[31:0], index_reg};
    assign m_axis_tlast  = (index_reg == INDEX_W'(ACTIVE_KEYS - 1));

    // input and output never open together
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken during a report");

    // an end beat starts the drain, never an immediate report
    a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && s_axis_tuser == ACT_END) |=> (state_reg == ST_DRAIN))
        else $error("end beat did not start the drain");

    // the row is empty of words while counts are shifted out
    a_row_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (beat_live == '0))
        else $error("word still in the cell row during a report");

    // the closing beat of a report hands back to the input side
    a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && m_axis_tlast) |=> s_axis_tready)
        else $error("input not reopened after the report");

    // counters are all clear once a report is over
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && m_axis_tlast) |=> (counts[0] == '0))
        else $error("counters not cleared by the report");

endmodule
